// File: hdl/md5_pkg.sv
// Constants, types and helper functions for the streaming MD5 engine.
// No dependencies; imported by md5_stream_hash_top.
package md5_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] IV_A = 32'h67452301;
  localparam logic [WordW-1:0] IV_B = 32'hefcdab89;
  localparam logic [WordW-1:0] IV_C = 32'h98badcfe;
  localparam logic [WordW-1:0] IV_D = 32'h10325476;

  localparam logic [WordW-1:0] PAD_BYTE = 32'h0000_0080;

  // Padding progress codes
  localparam logic [1:0] PAD_NONE  = 2'd0;
  localparam logic [1:0] PAD_MARK  = 2'd1;
  localparam logic [1:0] PAD_ZERO  = 2'd2;
  localparam logic [1:0] PAD_LENHI = 2'd3;

  localparam logic [3:0] LEN_LO_SLOT = 4'd14;
  localparam logic [3:0] LAST_SLOT   = 4'd15;
  localparam logic [5:0] LAST_ROUND  = 6'd63;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FINAL = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t md5_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount: row is the round group, column is the round index mod 4
  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic word_t rotl32(input word_t x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

// File: hdl/md5_stream_hash_top.sv
// Streaming MD5 engine: word buffer, padding sequencer and one round unit.
// Depends on md5_pkg.
//
// Takes a message as 32-bit little-endian words (first byte in bits 7..0) and
// returns its 128-bit MD5 digest as four little-endian words once the word
// marked last has been taken. The message must not be empty; on the last word
// byte_count gives the valid bytes (0 adds none, values above 4 count as 4) and
// the bytes above the count are ignored. Words are taken while the engine is
// idle; after the sixteenth word of a block it takes no words while it runs
// one MD5 round per cycle through a single shared round unit (64 rounds) and
// then folds the result into the chaining values. After the last word, the
// engine writes one padding word per cycle (zeros, the 0x80 marker and the
// 64-bit bit length) and runs one or two more compressions before the digest
// appears. The digest sits in an output register; a new message can start
// while it waits, but the next digest holds in the engine until the previous
// one has been taken.
module md5_stream_hash_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  md5_pkg::word_t      in_data_word,
  input  logic [2:0]          in_byte_count,
  input  logic                in_last_word,
  output logic                out_valid,
  input  logic                out_ready,
  output md5_pkg::word_t      out_digest_a,
  output md5_pkg::word_t      out_digest_b,
  output md5_pkg::word_t      out_digest_c,
  output md5_pkg::word_t      out_digest_d
);
  import md5_pkg::*;

  state_t      state_r, state_nxt;
  logic [1:0]  pad_r, pad_nxt;
  word_t       chain_r [4];
  word_t       abcd_r  [4];
  word_t       block_r [16];
  word_t       dig_r   [4];
  logic [5:0]  round_r;
  logic [3:0]  fill_r;
  logic [63:0] bitlen_r;
  logic        out_valid_r;

  logic        in_xfer;
  logic        wr_en;
  word_t       wr_data;
  logic [5:0]  len_add;
  logic [2:0]  cnt;
  logic        start_cmp;
  logic        emit_go;

  // Round unit signals
  word_t       f_val, m_val, x_val, t_val;
  logic [3:0]  g_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_digest_a = dig_r[0];
  assign out_digest_b = dig_r[1];
  assign out_digest_c = dig_r[2];
  assign out_digest_d = dig_r[3];

  assign cnt       = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
  assign start_cmp = wr_en && (fill_r == LAST_SLOT);
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Sequencer: buffer writes, padding steps and compression hand-off
  always_comb begin
    state_nxt = state_r;
    pad_nxt   = pad_r;
    wr_en     = 1'b0;
    wr_data   = '0;
    len_add   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wr_en = 1'b1;
          if (!in_last_word) begin
            wr_data = in_data_word;
            len_add = 6'd32;
          end else begin
            len_add = {cnt, 3'b000};
            pad_nxt = PAD_ZERO;
            case (cnt)
              3'd0: wr_data = PAD_BYTE;
              3'd1: wr_data = {16'h0000, 8'h80, in_data_word[7:0]};
              3'd2: wr_data = {8'h00, 8'h80, in_data_word[15:0]};
              3'd3: wr_data = {8'h80, in_data_word[23:0]};
              default: begin
                wr_data = in_data_word;
                pad_nxt = PAD_MARK;
              end
            endcase
          end
          if (fill_r == LAST_SLOT) begin
            state_nxt = S_ROUND;
          end else if (in_last_word) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en = 1'b1;
        case (pad_r)
          PAD_MARK: begin
            wr_data = PAD_BYTE;
            pad_nxt = PAD_ZERO;
          end
          PAD_ZERO: begin
            if (fill_r == LEN_LO_SLOT) begin
              wr_data = bitlen_r[31:0];
              pad_nxt = PAD_LENHI;
            end
          end
          PAD_LENHI: wr_data = bitlen_r[63:32];
          default:   wr_data = '0;
        endcase
        if (fill_r == LAST_SLOT) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round_r == LAST_ROUND) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        case (pad_r)
          PAD_NONE:  state_nxt = S_IDLE;
          PAD_LENHI: state_nxt = S_EMIT;
          default:   state_nxt = S_PAD;
        endcase
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
          pad_nxt   = PAD_NONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shared round unit: one MD5 round per cycle
  always_comb begin
    case (round_r[5:4])
      2'd0: begin
        f_val = (abcd_r[1] & abcd_r[2]) | (~abcd_r[1] & abcd_r[3]);
        g_idx = round_r[3:0];
      end
      2'd1: begin
        f_val = (abcd_r[3] & abcd_r[1]) | (~abcd_r[3] & abcd_r[2]);
        g_idx = round_r[3:0] * 4'd5 + 4'd1;
      end
      2'd2: begin
        f_val = abcd_r[1] ^ abcd_r[2] ^ abcd_r[3];
        g_idx = round_r[3:0] * 4'd3 + 4'd5;
      end
      default: begin
        f_val = abcd_r[2] ^ (abcd_r[1] | ~abcd_r[3]);
        g_idx = round_r[3:0] * 4'd7;
      end
    endcase
    m_val = block_r[g_idx];
    x_val = abcd_r[0] + f_val + md5_k(round_r) + m_val;
    t_val = abcd_r[1] + rotl32(x_val, md5_rot(round_r));
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pad_r       <= PAD_NONE;
      chain_r[0]  <= IV_A;
      chain_r[1]  <= IV_B;
      chain_r[2]  <= IV_C;
      chain_r[3]  <= IV_D;
      round_r     <= '0;
      fill_r      <= '0;
      bitlen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pad_r   <= pad_nxt;
      if (wr_en) begin
        fill_r <= fill_r + 4'd1;
      end
      if (in_xfer) begin
        bitlen_r <= bitlen_r + 64'(len_add);
      end
      if (start_cmp) begin
        round_r <= '0;
      end else if (state_r == S_ROUND) begin
        round_r <= round_r + 6'd1;
      end
      if (state_r == S_FINAL) begin
        for (int i = 0; i < 4; i++) begin
          chain_r[i] <= chain_r[i] + abcd_r[i];
        end
      end
      // Hand the digest to the output register and clear for the next message
      if (emit_go) begin
        chain_r[0]  <= IV_A;
        chain_r[1]  <= IV_B;
        chain_r[2]  <= IV_C;
        chain_r[3]  <= IV_D;
        fill_r      <= '0;
        bitlen_r    <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: block buffer, working registers and digest
  always_ff @(posedge clk) begin
    if (wr_en) begin
      block_r[fill_r] <= wr_data;
    end
    if (start_cmp) begin
      for (int i = 0; i < 4; i++) begin
        abcd_r[i] <= chain_r[i];
      end
    end else if (state_r == S_ROUND) begin
      abcd_r[0] <= abcd_r[3];
      abcd_r[1] <= t_val;
      abcd_r[2] <= abcd_r[1];
      abcd_r[3] <= abcd_r[2];
    end
    if (emit_go) begin
      for (int i = 0; i < 4; i++) begin
        dig_r[i] <= chain_r[i];
      end
    end
  end

endmodule
